// ----- src/pcm_mix_pkg.sv -----
package pcm_mix_pkg;

    // input item codes, carried in s_axis tuser
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_START = 2'd1;
    localparam t_mode MODE_STOP  = 2'd2;
    localparam t_mode MODE_TICK  = 2'd3;

    localparam int CHAN_FIELD_W = 2;
    localparam int ADDR_FIELD_W = 16;
    localparam int SAMPLE_W     = 8;
    localparam int LEN_W        = 17;
    localparam int MASK_W       = 4;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 16;

    localparam logic [SAMPLE_W-1:0] SILENCE   = 8'h80;
    localparam logic [SAMPLE_W-1:0] MAX_LEVEL = 8'hFF;

    typedef logic [LEN_W-1:0] t_len;

    // channel state carried from the read stage to the update stage
    typedef struct packed {
        logic on;
        logic rep;
        t_len len;
        t_len pos;
    } t_voice;

    // add one sample around the silence level, clamp to the byte range
    function automatic logic [SAMPLE_W-1:0] mix_add(input logic [SAMPLE_W-1:0] acc,
                                                    input logic [SAMPLE_W-1:0] smp);
        logic signed [SAMPLE_W+1:0] sum;
        sum = $signed({2'b00, acc}) + $signed({2'b00, smp}) - $signed({2'b00, SILENCE});
        if (sum < 0) begin
            return '0;
        end else if (sum > $signed({2'b00, MAX_LEVEL})) begin
            return MAX_LEVEL;
        end else begin
            return sum[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ----- src/pcm_mix_sample_ram.sv -----
module pcm_mix_sample_ram #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [7:0]           i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [7:0]           o_rd_data
);

    logic [7:0] r_mem [2**ADDR_BITS];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/pcm_channel_mixer_unit.sv -----
// Mixer for unsigned 8-bit PCM held in an on-chip sample memory.
// One input stream (s_axis) carries commands: tuser selects load byte,
// start channel, stop channel or tick. Load, start and stop take one beat
// and give no output; the block is ready again next cycle.
// A tick produces one output beat (m_axis): the mix of all playing
// channels starting at 128, clamped to 0..255 after each channel, plus a
// mask of the channels still playing afterwards.
// A tick passes each channel through a read stage and an update stage:
// the single sample memory port reads one channel per cycle, with the
// update of each channel in the cycle after its read.
// No new command is taken while a tick is in progress, so a new tick
// is not accepted before the last one is through.
// The output register holds a result until the receiver takes it; a later
// command is still accepted meanwhile, but a following tick waits at its
// end until the output register is free.
// Reset stops all channels and empties the output register; the sample
// memory keeps its contents and must be loaded before any channel plays it.
module pcm_channel_mixer_unit #(
    parameter int CHANNELS  = 4,
    parameter int ADDR_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // channel[1:0], address[17:2], data_byte[25:18], sample_length[42:26],
    // loop_enable[43], zero[47:44]
    input  logic [pcm_mix_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // mixed_sample[7:0], active_mask[11:8], zero[15:12]
    output logic [pcm_mix_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);

    import pcm_mix_pkg::*;

    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNELS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // input fields
    logic [CHAN_FIELD_W-1:0] w_channel;
    logic [ADDR_FIELD_W-1:0] w_address;
    logic [SAMPLE_W-1:0]     w_data_byte;
    t_len                    w_len;
    logic                    w_loop;
    t_mode                   w_mode;
    logic                    w_in_acc;
    logic                    w_ch_ok;
    logic [CH_BITS-1:0]      w_ch_idx;

    assign w_channel   = i_s_axis_tdata[1:0];
    assign w_address   = i_s_axis_tdata[17:2];
    assign w_data_byte = i_s_axis_tdata[25:18];
    assign w_len       = i_s_axis_tdata[42:26];
    assign w_loop      = i_s_axis_tdata[43];
    assign w_mode      = i_s_axis_tuser;
    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ch_ok     = (int'(w_channel) < CHANNELS);
    assign w_ch_idx    = CH_BITS'(w_channel);

    // channel state
    logic [ADDR_BITS-1:0] r_base [CHANNELS];
    t_len                 r_len  [CHANNELS];
    t_len                 r_pos  [CHANNELS];
    logic [CHANNELS-1:0]  r_rep;
    logic [CHANNELS-1:0]  r_on;

    // sequencer
    logic [1:0]          r_state;
    logic                r_issue;
    logic [CH_BITS-1:0]  r_rd_ch;
    logic                r_pipe_v;
    logic [CH_BITS-1:0]  r_pipe_ch;
    t_voice              r_pipe_voice;
    logic [SAMPLE_W-1:0] r_acc;

    // output register
    logic                r_out_v;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [MASK_W-1:0]   r_out_mask;
    logic                w_out_load;

    logic [ADDR_BITS-1:0] w_rd_addr;
    logic                 w_rd_en;
    logic                 w_wr_en;
    logic [SAMPLE_W-1:0]  w_rd_data;
    logic [MASK_W-1:0]    w_mask;

    logic [SAMPLE_W-1:0] n_acc;
    t_len                n_pos;
    logic                n_on;
    logic                w_stop_now;

    assign w_wr_en    = w_in_acc && (w_mode == MODE_LOAD);
    assign w_rd_en    = (r_state == ST_RUN) && r_issue;
    assign w_rd_addr  = r_base[r_rd_ch] + ADDR_BITS'(r_pos[r_rd_ch]);
    assign w_out_load = (r_state == ST_DONE) && (!r_out_v || i_m_axis_tready);

    pcm_mix_sample_ram #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (ADDR_BITS'(w_address)),
        .i_wr_data (w_data_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // update one channel with its sample
    always_comb begin
        n_acc      = r_acc;
        n_pos      = r_pipe_voice.pos;
        n_on       = r_pipe_voice.on;
        w_stop_now = 1'b0;
        if (r_pipe_voice.on) begin
            if (r_pipe_voice.len != '0) begin
                n_acc = mix_add(r_acc, w_rd_data);
                n_pos = r_pipe_voice.pos + 1'b1;
            end
            if (n_pos >= r_pipe_voice.len) begin
                n_pos = '0;
                if (!r_pipe_voice.rep) begin
                    n_on       = 1'b0;
                    w_stop_now = 1'b1;
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MASK_W; gi++) begin : g_mask
            if (gi < CHANNELS) begin : g_on
                assign w_mask[gi] = r_on[gi];
            end else begin : g_off
                assign w_mask[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issue  <= 1'b0;
            r_pipe_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_rep    <= '0;
            r_on     <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_base[i] <= '0;
                r_len[i]  <= '0;
                r_pos[i]  <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        case (w_mode)
                            MODE_START: begin
                                if (w_ch_ok) begin
                                    r_base[w_ch_idx] <= ADDR_BITS'(w_address);
                                    r_len[w_ch_idx]  <= w_len;
                                    r_pos[w_ch_idx]  <= '0;
                                    r_rep[w_ch_idx]  <= w_loop;
                                    r_on[w_ch_idx]   <= 1'b1;
                                end
                            end
                            MODE_STOP: begin
                                if (w_ch_ok) begin
                                    r_base[w_ch_idx] <= '0;
                                    r_len[w_ch_idx]  <= '0;
                                    r_pos[w_ch_idx]  <= '0;
                                    r_rep[w_ch_idx]  <= 1'b0;
                                    r_on[w_ch_idx]   <= 1'b0;
                                end
                            end
                            MODE_TICK: begin
                                r_acc    <= SILENCE;
                                r_rd_ch  <= '0;
                                r_issue  <= 1'b1;
                                r_pipe_v <= 1'b0;
                                r_state  <= ST_RUN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    // read stage: latch the channel state alongside its memory read
                    r_pipe_v     <= r_issue;
                    r_pipe_ch    <= r_rd_ch;
                    r_pipe_voice <= '{on:  r_on[r_rd_ch],
                                      rep: r_rep[r_rd_ch],
                                      len: r_len[r_rd_ch],
                                      pos: r_pos[r_rd_ch]};
                    if (r_issue) begin
                        if (r_rd_ch == LAST_CH) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_ch <= r_rd_ch + 1'b1;
                        end
                    end
                    // update stage
                    if (r_pipe_v) begin
                        r_acc            <= n_acc;
                        r_pos[r_pipe_ch] <= n_pos;
                        r_on[r_pipe_ch]  <= n_on;
                        if (w_stop_now) begin
                            r_base[r_pipe_ch] <= '0;
                            r_len[r_pipe_ch]  <= '0;
                            r_rep[r_pipe_ch]  <= 1'b0;
                        end
                        if (!r_issue) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (w_out_load) begin
                        r_out_sample <= r_acc;
                        r_out_mask   <= w_mask;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {(OUT_DATA_W - SAMPLE_W - MASK_W)'(0), r_out_mask, r_out_sample};

    // assertions

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_mode != MODE_TICK) && !r_out_v) |=> !r_out_v)
        else $error("result produced for a command other than tick");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_mode == MODE_STOP) && w_ch_ok) |=> !r_on[$past(w_ch_idx)])
        else $error("channel still on after stop");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_out_v || i_m_axis_tready))
            |=> (r_out_v && (r_state == ST_IDLE)))
        else $error("tick result not delivered to output register");

    generate
        for (gi = 0; gi < CHANNELS; gi++) begin : g_chk
            assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_on[gi] && (r_len[gi] != '0)) |-> (r_pos[gi] < r_len[gi]))
                else $error("play position beyond channel length");
        end
    endgenerate

endmodule
